// ===== rtl/lbs_pkg.sv =====
// Package for the linear blend skinning unit: constants, types and arithmetic helpers.
package lbs_pkg;

    localparam int BONE_COUNT_DEF = 64;
    localparam int INFLUENCES_DEF = 4;
    localparam int ENTRIES = 12;
    localparam int SLOT_W = 6;
    localparam int ENTRY_W = 4;
    localparam int DATA_W = 32;
    localparam int WEIGHT_W = 16;
    localparam int MAX_INF = 4;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_SKIN = 1'b1;

    typedef logic signed [DATA_W-1:0] word_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [ENTRY_W-1:0] entry;
        word_t value;
    } wr_t;

    // Saturate a wide signed value to 32 bits.
    function automatic word_t sat32(input logic signed [67:0] v);
        word_t r;
        if (v > 68'sh0_7FFF_FFFF)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < -68'sh0_8000_0000)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/lbs_if.sv =====
// Valid/ready stream interfaces for the skinning unit input and result channels.
interface lbs_in_if;
    logic valid;
    logic ready;
    logic operation;
    logic [5:0] bone_slot;
    logic [3:0] entry_index;
    logic signed [31:0] entry_value;
    logic [23:0] bone_ids;
    logic [63:0] bone_weights;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] nrm_x;
    logic signed [31:0] nrm_y;
    logic signed [31:0] nrm_z;
    modport source (output valid, operation, bone_slot, entry_index, entry_value, bone_ids,
        bone_weights, pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, input ready);
    modport sink (input valid, operation, bone_slot, entry_index, entry_value, bone_ids,
        bone_weights, pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, output ready);
endinterface

interface lbs_out_if;
    logic valid;
    logic ready;
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [31:0] out_nrm_x;
    logic signed [31:0] out_nrm_y;
    logic signed [31:0] out_nrm_z;
    modport source (output valid, out_pos_x, out_pos_y, out_pos_z, out_nrm_x, out_nrm_y,
        out_nrm_z, input ready);
    modport sink (input valid, out_pos_x, out_pos_y, out_pos_z, out_nrm_x, out_nrm_y,
        out_nrm_z, output ready);
endinterface

// ===== rtl/lbs_bone_mem.sv =====
// Bone matrix memory: one bank per influence slot, 12 words wide per bone row.
module lbs_bone_mem #(
    parameter int BONE_COUNT = lbs_pkg::BONE_COUNT_DEF,
    parameter int INFLUENCES = lbs_pkg::INFLUENCES_DEF
) (
    input  logic clk,
    input  logic wr_en,
    input  lbs_pkg::wr_t wr,
    input  logic rd_en,
    input  logic [INFLUENCES*lbs_pkg::SLOT_W-1:0] rd_ids,
    output logic [INFLUENCES*lbs_pkg::ENTRIES*lbs_pkg::DATA_W-1:0] rd_data
);
    localparam int AW = (BONE_COUNT > 1) ? $clog2(BONE_COUNT) : 1;
    localparam int ROW_W = lbs_pkg::ENTRIES * lbs_pkg::DATA_W;

    logic wr_ok;
    logic [AW-1:0] wr_addr;

    assign wr_ok = wr_en && ({3'b000, wr.slot} < 9'(BONE_COUNT))
        && (wr.entry < 4'(lbs_pkg::ENTRIES));
    assign wr_addr = AW'(wr.slot);

    // Each bank holds a full copy so all influences are read in parallel; rows that
    // name a bone out of range read as zero.
    for (genvar k = 0; k < INFLUENCES; k++)
    begin : g_bank
        logic [lbs_pkg::DATA_W-1:0] mem [BONE_COUNT][lbs_pkg::ENTRIES];
        logic [ROW_W-1:0] q_reg;
        logic [lbs_pkg::SLOT_W-1:0] id;
        logic in_range;

        assign id = rd_ids[k*lbs_pkg::SLOT_W +: lbs_pkg::SLOT_W];
        assign in_range = {3'b000, id} < 9'(BONE_COUNT);

        always_ff @(posedge clk)
        begin
            if (wr_ok)
            begin
                mem[wr_addr][wr.entry] <= wr.value;
            end
            if (rd_en)
            begin
                for (int e = 0; e < lbs_pkg::ENTRIES; e++)
                begin
                    q_reg[e*lbs_pkg::DATA_W +: lbs_pkg::DATA_W] <=
                        in_range ? mem[AW'(id)][e] : '0;
                end
            end
        end
        assign rd_data[k*ROW_W +: ROW_W] = q_reg;
    end
endmodule

// ===== rtl/lbs_datapath.sv =====
// Skinning datapath: weight blend, row products, rounding and saturation stages.
module lbs_datapath #(
    parameter int INFLUENCES = lbs_pkg::INFLUENCES_DEF
) (
    input  logic clk,
    input  logic en,
    input  logic [INFLUENCES*lbs_pkg::ENTRIES*lbs_pkg::DATA_W-1:0] mats,
    input  logic [INFLUENCES*lbs_pkg::WEIGHT_W-1:0] weights,
    input  logic signed [31:0] vec [6],
    output lbs_pkg::word_t res [6]
);
    localparam int ROW_W = lbs_pkg::ENTRIES * lbs_pkg::DATA_W;

    // Stage 1: products of matrix entries and weights.
    logic signed [48:0] prod_reg [INFLUENCES][lbs_pkg::ENTRIES];
    logic signed [31:0] v1_reg [6];
    // Stage 2: blended entries.
    lbs_pkg::word_t blend_reg [lbs_pkg::ENTRIES];
    logic signed [31:0] v2_reg [6];
    // Stage 3: row products.
    logic signed [63:0] p_reg [6][3];
    lbs_pkg::word_t t_reg [3];
    // Stage 4: results.
    lbs_pkg::word_t res_reg [6];

    logic signed [50:0] acc [lbs_pkg::ENTRIES];
    logic signed [51:0] rnd [lbs_pkg::ENTRIES];
    logic signed [67:0] dot [6];

    always_comb
    begin
        for (int e = 0; e < lbs_pkg::ENTRIES; e++)
        begin
            acc[e] = '0;
            for (int k = 0; k < INFLUENCES; k++)
            begin
                acc[e] = acc[e] + 51'(prod_reg[k][e]);
            end
            rnd[e] = (52'(acc[e]) + 52'sd16384) >>> 15;
        end
        for (int o = 0; o < 6; o++)
        begin
            dot[o] = 68'(p_reg[o][0]) + 68'(p_reg[o][1]) + 68'(p_reg[o][2]);
            dot[o] = (dot[o] + 68'sd32768) >>> 16;
            if (o < 3)
            begin
                dot[o] = dot[o] + 68'(t_reg[o]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < INFLUENCES; k++)
            begin
                for (int e = 0; e < lbs_pkg::ENTRIES; e++)
                begin
                    prod_reg[k][e] <= 49'($signed(mats[k*ROW_W + e*32 +: 32]))
                        * $signed({1'b0, weights[k*16 +: 16]});
                end
            end
            v1_reg <= vec;
            for (int e = 0; e < lbs_pkg::ENTRIES; e++)
            begin
                blend_reg[e] <= lbs_pkg::sat32(68'(rnd[e]));
            end
            v2_reg <= v1_reg;
            for (int r = 0; r < 3; r++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    p_reg[r][j] <= 64'(blend_reg[r*4+j]) * 64'(v2_reg[j]);
                    p_reg[r+3][j] <= 64'(blend_reg[r*4+j]) * 64'(v2_reg[j+3]);
                end
                t_reg[r] <= blend_reg[r*4+3];
            end
            for (int o = 0; o < 6; o++)
            begin
                res_reg[o] <= lbs_pkg::sat32(dot[o]);
            end
        end
    end

    assign res = res_reg;
endmodule

// ===== rtl/linear_blend_vertex_skinning_unit.sv =====
// Top level of the linear blend vertex skinning unit.
//  channel  direction  contents
//  in       sink       bone entry write or vertex to skin
//  out      source     deformed position and normal
// One item per cycle while out does not stall; a skin result is presented on out
// once it has passed through every pipeline stage listed below.
// The pipeline is memory read, weight product, blend, row product, round.
// A stall on out freezes the whole pipeline; a write lands in the bone memory at
// its transfer edge, so a skin in the very next cycle already reads the new entry.
// Reset clears pipeline valid bits; the bone memory is undefined until written.
module linear_blend_vertex_skinning_unit #(
    parameter int BONE_COUNT = lbs_pkg::BONE_COUNT_DEF,
    parameter int INFLUENCES = lbs_pkg::INFLUENCES_DEF
) (
    input logic clk,
    input logic rst_n,
    lbs_in_if.sink in,
    lbs_out_if.source out
);
    localparam int STAGES = 5;

    logic en;
    logic take;
    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;
    lbs_pkg::wr_t wr;
    logic signed [31:0] vec0_reg [6];
    logic signed [31:0] vec_in [6];
    logic [INFLUENCES*16-1:0] w_reg;
    logic [INFLUENCES*lbs_pkg::ENTRIES*32-1:0] mats;
    lbs_pkg::word_t res [6];

    assign en = !vld_reg[STAGES-1] || out.ready;
    assign in.ready = en;
    assign take = in.valid && en;
    assign wr = '{slot: in.bone_slot, entry: in.entry_index, value: in.entry_value};
    assign vec_in = '{in.pos_x, in.pos_y, in.pos_z, in.nrm_x, in.nrm_y, in.nrm_z};

    assign vld_next = {vld_reg[STAGES-2:0], take && (in.operation == lbs_pkg::OP_SKIN)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vec0_reg <= vec_in;
            w_reg <= in.bone_weights[INFLUENCES*16-1:0];
        end
    end

    lbs_bone_mem #(.BONE_COUNT(BONE_COUNT), .INFLUENCES(INFLUENCES)) u_mem (
        .clk(clk),
        .wr_en(take && (in.operation == lbs_pkg::OP_WRITE)),
        .wr(wr),
        .rd_en(en),
        .rd_ids(in.bone_ids[INFLUENCES*6-1:0]),
        .rd_data(mats)
    );

    lbs_datapath #(.INFLUENCES(INFLUENCES)) u_dp (
        .clk(clk),
        .en(en),
        .mats(mats),
        .weights(w_reg),
        .vec(vec0_reg),
        .res(res)
    );

    assign out.valid = vld_reg[STAGES-1];
    assign out.out_pos_x = res[0];
    assign out.out_pos_y = res[1];
    assign out.out_pos_z = res[2];
    assign out.out_nrm_x = res[3];
    assign out.out_nrm_y = res[4];
    assign out.out_nrm_z = res[5];
endmodule

// ===== rtl/lbs_checker.sv =====
// Port-level assertions for the skinning unit, bound to the top level.
module lbs_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready
);
    a_stall_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready) else $error("ready high while stalled");
    a_free_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready) else $error("ready low with empty output");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({in_valid, in_ready, out_valid}))
        else $error("handshake signal unknown");
endmodule

bind linear_blend_vertex_skinning_unit lbs_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in.valid), .in_ready(in.ready),
    .out_valid(out.valid), .out_ready(out.ready)
);
